/* rtl/hfii_pkg.sv */
// Shared types, constants and the microcode table of the Haar feature unit.
`default_nettype none

package hfii_pkg;

	localparam int unsigned STRIDE_W = 11;
	localparam int unsigned CORD_W   = 12;	// padded row or column of one corner
	localparam int unsigned CA_W     = 24;	// full corner address before the range check
	localparam int unsigned PC_W     = 6;

	localparam logic [STRIDE_W-1:0] STRIDE_RESET = 11'd128;

	localparam logic REQ_WRITE   = 1'b0;
	localparam logic REQ_FEATURE = 1'b1;

	localparam logic [2:0] FT_TWO_H   = 3'd0;
	localparam logic [2:0] FT_TWO_V   = 3'd1;
	localparam logic [2:0] FT_THREE_H = 3'd2;
	localparam logic [2:0] FT_CHECKER = 3'd3;
	localparam logic [2:0] FT_THREE_V = 3'd4;

	localparam logic [PC_W-1:0] ENT_TWO_H   = 6'd0;
	localparam logic [PC_W-1:0] ENT_TWO_V   = 6'd6;
	localparam logic [PC_W-1:0] ENT_THREE_H = 6'd12;
	localparam logic [PC_W-1:0] ENT_CHECKER = 6'd20;
	localparam logic [PC_W-1:0] ENT_THREE_V = 6'd29;
	localparam logic [PC_W-1:0] ENT_ZERO    = 6'd37;

	typedef struct packed {
		logic        req_type;
		logic [13:0] write_addr;
		logic [31:0] write_value;
		logic [2:0]  feature_type;
		logic [9:0]  start_x;
		logic [9:0]  start_y;
		logic [9:0]  scale_x;
		logic [9:0]  scale_y;
	} req_t;

	typedef struct packed {
		logic signed [31:0] feature_value;
		logic               address_error;
	} rsp_t;

	// weight applied to one corner word
	typedef enum logic [2:0] {
		COEF_ZERO,
		COEF_P1,
		COEF_M1,
		COEF_P2,
		COEF_M2,
		COEF_P3,
		COEF_M3,
		COEF_P4
	} coef_t;

	typedef struct packed {
		logic [1:0] col;	// grid column of the corner
		logic [1:0] row;	// grid row of the corner
		coef_t      coef;
		logic       check;	// bottom-right corner: test it against the memory size
		logic       first;	// opens the sum
		logic       last;	// closes the routine
	} ucode_t;

	typedef struct packed {
		logic   vld;
		ucode_t uw;
	} ctrl_t;

	function automatic ucode_t mk(input logic [1:0] c, input logic [1:0] r,
			input coef_t k, input logic head, input logic tail);
		ucode_t w;
		w.col   = c;
		w.row   = r;
		w.coef  = k;
		w.check = head;
		w.first = head;
		w.last  = tail;
		return w;
	endfunction

	function automatic logic [PC_W-1:0] entry_pc(input logic [2:0] ft);
		logic [PC_W-1:0] p;
		unique case (ft)
			FT_TWO_H:   p = ENT_TWO_H;
			FT_TWO_V:   p = ENT_TWO_V;
			FT_THREE_H: p = ENT_THREE_H;
			FT_CHECKER: p = ENT_CHECKER;
			FT_THREE_V: p = ENT_THREE_V;
			default:    p = ENT_ZERO;
		endcase
		return p;
	endfunction

	// Each known pattern's routine opens with its bottom-right corner, which is the highest address.
	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		unique case (pc)
			// two side by side
			6'd0:  w = mk(2'd2, 2'd1, COEF_M1, 1'b1, 1'b0);
			6'd1:  w = mk(2'd0, 2'd0, COEF_P1, 1'b0, 1'b0);
			6'd2:  w = mk(2'd0, 2'd1, COEF_M1, 1'b0, 1'b0);
			6'd3:  w = mk(2'd1, 2'd0, COEF_M2, 1'b0, 1'b0);
			6'd4:  w = mk(2'd1, 2'd1, COEF_P2, 1'b0, 1'b0);
			6'd5:  w = mk(2'd2, 2'd0, COEF_P1, 1'b0, 1'b1);
			// two stacked
			6'd6:  w = mk(2'd1, 2'd2, COEF_M1, 1'b1, 1'b0);
			6'd7:  w = mk(2'd0, 2'd0, COEF_P1, 1'b0, 1'b0);
			6'd8:  w = mk(2'd0, 2'd2, COEF_P1, 1'b0, 1'b0);
			6'd9:  w = mk(2'd1, 2'd0, COEF_M1, 1'b0, 1'b0);
			6'd10: w = mk(2'd0, 2'd1, COEF_M2, 1'b0, 1'b0);
			6'd11: w = mk(2'd1, 2'd1, COEF_P2, 1'b0, 1'b1);
			// three side by side
			6'd12: w = mk(2'd3, 2'd1, COEF_P1, 1'b1, 1'b0);
			6'd13: w = mk(2'd0, 2'd0, COEF_P1, 1'b0, 1'b0);
			6'd14: w = mk(2'd0, 2'd1, COEF_M1, 1'b0, 1'b0);
			6'd15: w = mk(2'd3, 2'd0, COEF_M1, 1'b0, 1'b0);
			6'd16: w = mk(2'd1, 2'd0, COEF_M3, 1'b0, 1'b0);
			6'd17: w = mk(2'd2, 2'd1, COEF_M3, 1'b0, 1'b0);
			6'd18: w = mk(2'd1, 2'd1, COEF_P3, 1'b0, 1'b0);
			6'd19: w = mk(2'd2, 2'd0, COEF_P3, 1'b0, 1'b1);
			// checkerboard
			6'd20: w = mk(2'd2, 2'd2, COEF_P1, 1'b1, 1'b0);
			6'd21: w = mk(2'd0, 2'd0, COEF_P1, 1'b0, 1'b0);
			6'd22: w = mk(2'd0, 2'd2, COEF_P1, 1'b0, 1'b0);
			6'd23: w = mk(2'd2, 2'd0, COEF_P1, 1'b0, 1'b0);
			6'd24: w = mk(2'd0, 2'd1, COEF_M2, 1'b0, 1'b0);
			6'd25: w = mk(2'd1, 2'd2, COEF_M2, 1'b0, 1'b0);
			6'd26: w = mk(2'd1, 2'd0, COEF_M2, 1'b0, 1'b0);
			6'd27: w = mk(2'd2, 2'd1, COEF_M2, 1'b0, 1'b0);
			6'd28: w = mk(2'd1, 2'd1, COEF_P4, 1'b0, 1'b1);
			// three stacked
			6'd29: w = mk(2'd1, 2'd3, COEF_P1, 1'b1, 1'b0);
			6'd30: w = mk(2'd0, 2'd0, COEF_P1, 1'b0, 1'b0);
			6'd31: w = mk(2'd0, 2'd3, COEF_M1, 1'b0, 1'b0);
			6'd32: w = mk(2'd1, 2'd0, COEF_M1, 1'b0, 1'b0);
			6'd33: w = mk(2'd0, 2'd1, COEF_M3, 1'b0, 1'b0);
			6'd34: w = mk(2'd1, 2'd2, COEF_M3, 1'b0, 1'b0);
			6'd35: w = mk(2'd0, 2'd2, COEF_P3, 1'b0, 1'b0);
			6'd36: w = mk(2'd1, 2'd1, COEF_P3, 1'b0, 1'b1);
			// unknown pattern: one empty word, result zero
			default: begin
				w       = mk(2'd0, 2'd0, COEF_ZERO, 1'b0, 1'b1);
				w.first = 1'b1;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

/* rtl/hfii_seq.sv */
// Microcode sequencer: step counter, dispatch on pattern and control word issue.
`default_nettype none

module hfii_seq (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                ld,
	input  wire logic [2:0]          ftype,
	input  wire logic                fin,
	output logic                     busy,
	output hfii_pkg::ctrl_t          ctrl
);
	import hfii_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_WAIT
	} st_t;

	st_t             st_q;
	logic [PC_W-1:0] pc_q;
	ucode_t          uw;

	assign uw        = ucode_rom(pc_q);
	assign ctrl.vld  = (st_q == S_RUN);
	assign ctrl.uw   = uw;
	assign busy      = (st_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			pc_q <= '0;
		end else begin
			unique case (st_q)
				S_IDLE: if (ld) begin
					pc_q <= entry_pc(ftype);
					st_q <= S_RUN;
				end
				S_RUN: begin
					pc_q <= pc_q + PC_W'(1);
					if (uw.last) st_q <= S_WAIT;
				end
				// hold until the last word leaves the datapath
				S_WAIT: if (fin) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/hfii_dp.sv */
// Datapath: corner address, integral memory, range check and weighted accumulate.
`default_nettype none

module hfii_dp #(
	parameter int unsigned MEM_DEPTH = 16384
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire hfii_pkg::req_t                req,
	input  wire logic                          wr_en,
	input  wire logic                          ld,
	input  wire logic                          cfg_we,
	input  wire logic [hfii_pkg::STRIDE_W-1:0] cfg_data,
	input  wire hfii_pkg::ctrl_t               ctrl,
	output logic                               fin,
	output logic                               done,
	output hfii_pkg::rsp_t                     rsp
);
	import hfii_pkg::*;

	localparam int unsigned AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	logic [31:0]         mem [MEM_DEPTH];

	logic [STRIDE_W-1:0] stride_q;
	logic [9:0]          x0_q, y0_q, sx_q, sy_q;

	logic [CORD_W-1:0]   row_c, col_c;
	logic [CA_W-1:0]     prod_c;

	logic                vld_s1;
	ucode_t              uw_s1;
	logic [CA_W-1:0]     prod_s1;
	logic [CORD_W-1:0]   col_s1;

	logic [CA_W-1:0]     addr_c;
	logic                oob_c;
	logic                wr_ok;

	logic                vld_s2;
	ucode_t              uw_s2;
	logic                err_s2;
	logic [31:0]         rd_s2;

	logic [31:0]         term_c, acc_c, acc_q;
	logic                err_c, err_q;
	logic                done_q;
	rsp_t                rsp_q;

	// corner position in the padded image
	assign row_c  = CORD_W'(y0_q) + CORD_W'(ctrl.uw.row) * CORD_W'(sy_q) + CORD_W'(1);
	assign col_c  = CORD_W'(x0_q) + CORD_W'(ctrl.uw.col) * CORD_W'(sx_q) + CORD_W'(1);
	assign prod_c = CA_W'(row_c) * CA_W'(stride_q);

	assign addr_c = prod_s1 + CA_W'(col_s1);
	assign oob_c  = (addr_c >= CA_W'(MEM_DEPTH));
	assign wr_ok  = (CA_W'(req.write_addr) < CA_W'(MEM_DEPTH));

	always_comb begin
		unique case (uw_s2.coef)
			COEF_P1: term_c = rd_s2;
			COEF_M1: term_c = -rd_s2;
			COEF_P2: term_c = rd_s2 << 1;
			COEF_M2: term_c = -(rd_s2 << 1);
			COEF_P3: term_c = rd_s2 + (rd_s2 << 1);
			COEF_M3: term_c = -(rd_s2 + (rd_s2 << 1));
			COEF_P4: term_c = rd_s2 << 2;
			default: term_c = '0;
		endcase
	end

	assign acc_c = (uw_s2.first ? 32'd0 : acc_q) + term_c;
	assign err_c = (uw_s2.first ? 1'b0 : err_q) | err_s2;
	assign fin   = vld_s2 && uw_s2.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_q <= STRIDE_RESET;
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			if (cfg_we) stride_q <= cfg_data;
			vld_s1 <= ctrl.vld;
			vld_s2 <= vld_s1;
			done_q <= fin;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			x0_q <= req.start_x;
			y0_q <= req.start_y;
			sx_q <= req.scale_x;
			sy_q <= req.scale_y;
		end
		uw_s1   <= ctrl.uw;
		prod_s1 <= prod_c;
		col_s1  <= col_c;
		uw_s2   <= uw_s1;
		err_s2  <= uw_s1.check && oob_c;
		if (vld_s2) begin
			acc_q <= acc_c;
			err_q <= err_c;
			if (uw_s2.last) begin
				rsp_q.feature_value <= err_c ? 32'sd0 : $signed(acc_c);
				rsp_q.address_error <= err_c;
			end
		end
	end

	// single port: writes only while idle, reads only while a routine runs
	always_ff @(posedge clk) begin
		if (wr_en && wr_ok) mem[AW'(req.write_addr)] <= req.write_value;
		if (vld_s1) rd_s2 <= mem[addr_c[AW-1:0]];
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

`default_nettype wire

/* rtl/haar_feature_from_integral_image.sv */
// Top level of the Haar feature unit over a stored integral image.
`default_nettype none

// Usage
//   Request channel: an item (req) is taken at a rising edge with start high and
//   busy low. A write item stores req.write_value at req.write_addr if that
//   address is inside the memory; it gives no result and leaves busy low. A
//   feature item raises busy while the sequencer steps through its routine, one
//   corner read a cycle from the single memory port.
//   Result channel: done is high for exactly one cycle with rsp; the receiver
//   cannot stall it and must take it then.
//   Sequence: each corner word has its row product formed as it is issued. It
//   is registered into s1, where its address is summed, checked against the
//   memory depth if it is the bottom-right corner, and read into s2; there it
//   is weighted and accumulated. The sum after the last word is registered
//   onto rsp as done rises; its word is taken at the edge that ends the done
//   cycle. busy drops as done rises, so the next item may be taken at that same
//   edge; no new item is taken while a feature is in flight.
//   Configuration: row_stride is written on cfg_data when cfg_valid is high;
//   cfg_ready is always high. Write it only while the block is idle.
//   Reset: arst_n clears the sequencer and sets row_stride to 128. The memory
//   is not cleared; read only words that have been written.
module haar_feature_from_integral_image #(
	parameter int unsigned MEM_DEPTH = 16384
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire hfii_pkg::req_t                req,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [hfii_pkg::STRIDE_W-1:0] cfg_data,
	output logic                               done,
	output hfii_pkg::rsp_t                     rsp
);
	import hfii_pkg::*;

	logic  acc_w;
	logic  ld;
	logic  wr_en;
	logic  fin;
	ctrl_t ctrl;

	assign cfg_ready = 1'b1;
	assign acc_w     = start && !busy;
	assign ld        = acc_w && (req.req_type == REQ_FEATURE);
	assign wr_en     = acc_w && (req.req_type == REQ_WRITE);

	hfii_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.ld     (ld),
		.ftype  (req.feature_type),
		.fin    (fin),
		.busy   (busy),
		.ctrl   (ctrl)
	);

	hfii_dp #(
		.MEM_DEPTH (MEM_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.wr_en    (wr_en),
		.ld       (ld),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.ctrl     (ctrl),
		.fin      (fin),
		.done     (done),
		.rsp      (rsp)
	);

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result word without a running routine");

	a_error_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.address_error) |-> (rsp.feature_value == 32'sd0))
		else $error("address error with a nonzero value");

	a_feature_holds_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ld |=> busy)
		else $error("feature word taken but sequencer not started");

	a_issue_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.vld |-> busy)
		else $error("control word issued while idle");

endmodule

`default_nettype wire
